### hdl/cdau_pkg.sv
// Shared types, constants and calendar helper functions for the date adder.
package cdau_pkg;

	localparam logic [11:0] YearMin = 12'd1900;
	localparam logic [11:0] YearMax = 12'd2100;

	// Operation codes. The last one returns the input date unchanged.
	localparam logic [1:0] OP_DAYS   = 2'd0;
	localparam logic [1:0] OP_MONTHS = 2'd1;
	localparam logic [1:0] OP_YEARS  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_YEAR  = 2'd1;
	localparam logic [1:0] ERR_MONTH = 2'd2;
	localparam logic [1:0] ERR_DAY   = 2'd3;

	// Days from 1900-01-01 to 2101-01-01.
	localparam logic [16:0] DaysSpan = 17'd73414;

	// Offset that makes month plus amount non-negative, as a multiple of twelve.
	localparam logic [14:0] MonQOffset = 15'd10923;
	localparam logic [18:0] MonOffset  = 19'd131076;

	// Reciprocals for division by twelve (shift 24) and by 365 (shift 26).
	localparam logic [20:0] Recip12  = 21'd1398102;
	localparam logic [17:0] Recip365 = 18'd183860;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  mon;
		logic [11:0] year;
		logic [1:0]  err;
	} date_t;

	typedef struct packed {
		logic               fin;
		date_t              res;
		logic [1:0]         op;
		logic [4:0]         day;
		logic [3:0]         mon;
		logic [11:0]        year;
		logic               leap;
		logic signed [18:0] t;
		logic [18:0]        vp;
		logic signed [19:0] ny;
	} s1_t;

	typedef struct packed {
		logic        fin;
		date_t       res;
		logic [1:0]  op;
		logic [4:0]  day;
		logic [11:0] year;
		logic [16:0] a;
		logic [18:0] vp;
		logic [14:0] q;
	} s2_t;

	typedef struct packed {
		logic               fin;
		date_t              res;
		logic [1:0]         op;
		logic [4:0]         day;
		logic [16:0]        a;
		logic [7:0]         est;
		logic [3:0]         r;
		logic signed [16:0] ny;
	} s3_t;

	typedef struct packed {
		logic        fin;
		date_t       res;
		logic [16:0] a;
		logic [7:0]  est;
		logic [16:0] e_hi;
		logic [16:0] e_lo;
	} s4_t;

	typedef struct packed {
		logic        fin;
		date_t       res;
		logic [8:0]  rem;
		logic [11:0] year;
		logic        leap;
	} s5_t;

	// Leap test, exact for years 1900 to 2100.
	function automatic logic leap_yr(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != 12'd1900) && (y != 12'd2100);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd1:                      n = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	// Days of the year before the first of month m.
	function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd31;
			4'd2:    n = 9'd59;
			4'd3:    n = 9'd90;
			4'd4:    n = 9'd120;
			4'd5:    n = 9'd151;
			4'd6:    n = 9'd181;
			4'd7:    n = 9'd212;
			4'd8:    n = 9'd243;
			4'd9:    n = 9'd273;
			4'd10:   n = 9'd304;
			4'd11:   n = 9'd334;
			default: n = 9'd0;
		endcase
		if (leap && m >= 4'd2 && m <= 4'd11) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

	// Days from 1900-01-01 to January 1 of year 1900 + k, for k up to 201.
	function automatic logic [16:0] days_before(input logic [7:0] k);
		logic [11:0] ym1;
		logic [16:0] h;
		logic [16:0] g;
		ym1 = 12'd1899 + {4'd0, k};
		if (ym1 >= 12'd2100) begin
			h = 17'd21;
		end else if (ym1 >= 12'd2000) begin
			h = 17'd20;
		end else if (ym1 >= 12'd1900) begin
			h = 17'd19;
		end else begin
			h = 17'd18;
		end
		g = (ym1 >= 12'd2000) ? 17'd5 : 17'd4;
		return 17'd365 * {9'd0, k} + {7'd0, ym1[11:2]} - h + g - 17'd460;
	endfunction

endpackage

### hdl/cdau_front.sv
// First stage: input date check, day of year and operand preparation.
module cdau_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  logic [1:0]           op,
	input  logic [4:0]           in_day,
	input  logic [3:0]           in_month,
	input  logic [11:0]          in_year,
	input  logic signed [17:0]   amount,
	output logic                 v_s1,
	output cdau_pkg::s1_t        d_s1
);

	cdau_pkg::s1_t nxt;
	logic          leap;
	logic [1:0]    err;

	always_comb begin
		leap = cdau_pkg::leap_yr(in_year);
		if (in_year < cdau_pkg::YearMin || in_year > cdau_pkg::YearMax) begin
			err = cdau_pkg::ERR_YEAR;
		end else if (in_month > 4'd11) begin
			err = cdau_pkg::ERR_MONTH;
		end else if (in_day == 5'd0 || in_day > cdau_pkg::month_len(in_month, leap)) begin
			err = cdau_pkg::ERR_DAY;
		end else begin
			err = cdau_pkg::ERR_NONE;
		end

		nxt.op   = op;
		nxt.day  = in_day;
		nxt.mon  = in_month;
		nxt.year = in_year;
		nxt.leap = leap;
		nxt.fin  = (err != cdau_pkg::ERR_NONE) || (op == cdau_pkg::OP_NOP);
		if (err != cdau_pkg::ERR_NONE) begin
			nxt.res = '{day: 5'd0, mon: 4'd0, year: 12'd0, err: err};
		end else begin
			nxt.res = '{day: in_day, mon: in_month, year: in_year, err: cdau_pkg::ERR_NONE};
		end
		nxt.t  = 19'(amount) + $signed({10'd0, cdau_pkg::cum_days(in_month, leap)})
			+ $signed({14'd0, in_day});
		nxt.vp = 19'(20'(amount) + 20'({16'd0, in_month}) + 20'(cdau_pkg::MonOffset));
		nxt.ny = 20'(amount) + $signed({8'd0, in_year});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

endmodule

### hdl/cdau_core.sv
// Second and third stages: year add, reciprocal divisions and month carry.
module cdau_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_s1,
	input  cdau_pkg::s1_t  d_s1,
	output logic           v_s3,
	output cdau_pkg::s3_t  d_s3
);

	cdau_pkg::s2_t nxt2;
	cdau_pkg::s2_t d_s2;
	cdau_pkg::s3_t nxt3;
	logic          v_s2;
	logic [17:0]   a_full;
	logic [4:0]    nd;
	logic [39:0]   prod12;
	logic [34:0]   prod365;
	logic [18:0]   rr;

	always_comb begin
		nxt2.fin  = d_s1.fin;
		nxt2.res  = d_s1.res;
		nxt2.op   = d_s1.op;
		nxt2.day  = d_s1.day;
		nxt2.year = d_s1.year;
		nxt2.vp   = d_s1.vp;
		a_full    = 18'({1'b0, cdau_pkg::days_before(8'(d_s1.year - cdau_pkg::YearMin))})
			+ 18'(d_s1.t) - 18'd1;
		nxt2.a    = a_full[16:0];
		prod12    = {21'd0, d_s1.vp} * {19'd0, cdau_pkg::Recip12};
		nxt2.q    = prod12[38:24];
		nd        = d_s1.day;
		if (!d_s1.fin) begin
			case (d_s1.op)
				cdau_pkg::OP_DAYS: begin
					if (d_s1.t <= 19'sd0) begin
						nxt2.fin = 1'b1;
					end else if (a_full >= {1'b0, cdau_pkg::DaysSpan}) begin
						nxt2.fin = 1'b1;
						nxt2.res = '{day: 5'd0, mon: 4'd0, year: 12'd0,
							err: cdau_pkg::ERR_YEAR};
					end
				end
				cdau_pkg::OP_YEARS: begin
					nxt2.fin = 1'b1;
					if (d_s1.ny < 20'sd1900 || d_s1.ny > 20'sd2100) begin
						nxt2.res = '{day: 5'd0, mon: 4'd0, year: 12'd0,
							err: cdau_pkg::ERR_YEAR};
					end else begin
						if (d_s1.leap && !cdau_pkg::leap_yr(d_s1.ny[11:0])
							&& d_s1.mon == 4'd1 && d_s1.day == 5'd29) begin
							nd = 5'd28;
						end
						nxt2.res = '{day: nd, mon: d_s1.mon, year: d_s1.ny[11:0],
							err: cdau_pkg::ERR_NONE};
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		nxt3.fin = d_s2.fin;
		nxt3.res = d_s2.res;
		nxt3.op  = d_s2.op;
		nxt3.day = d_s2.day;
		nxt3.a   = d_s2.a;
		prod365  = {18'd0, d_s2.a} * {17'd0, cdau_pkg::Recip365};
		nxt3.est = prod365[33:26];
		rr       = d_s2.vp - 19'(20'd12 * {5'd0, d_s2.q});
		if (rr >= 19'd12) begin
			rr = rr - 19'd12;
		end
		nxt3.r   = rr[3:0];
		nxt3.ny  = $signed({5'd0, d_s2.year}) + $signed({2'd0, d_s2.q})
			- $signed({2'd0, cdau_pkg::MonQOffset});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= nxt2;
			d_s3 <= nxt3;
		end
	end

endmodule

### hdl/cdau_year.sv
// Fourth and fifth stages: month result and the year found by the day walk.
module cdau_year (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_s3,
	input  cdau_pkg::s3_t  d_s3,
	output logic           v_s5,
	output cdau_pkg::s5_t  d_s5
);

	cdau_pkg::s4_t nxt4;
	cdau_pkg::s4_t d_s4;
	cdau_pkg::s5_t nxt5;
	logic          v_s4;
	logic [4:0]    lim;
	logic          sel;
	logic [16:0]   e;
	logic [7:0]    idx;
	logic [16:0]   diff;

	always_comb begin
		nxt4.fin  = d_s3.fin;
		nxt4.res  = d_s3.res;
		nxt4.a    = d_s3.a;
		nxt4.est  = d_s3.est;
		nxt4.e_hi = cdau_pkg::days_before(d_s3.est);
		nxt4.e_lo = cdau_pkg::days_before(d_s3.est - 8'd1);
		lim       = cdau_pkg::month_len(d_s3.r, cdau_pkg::leap_yr(d_s3.ny[11:0]));
		if (!d_s3.fin && d_s3.op == cdau_pkg::OP_MONTHS) begin
			nxt4.fin = 1'b1;
			if (d_s3.ny < 17'sd1900 || d_s3.ny > 17'sd2100) begin
				nxt4.res = '{day: 5'd0, mon: 4'd0, year: 12'd0, err: cdau_pkg::ERR_YEAR};
			end else begin
				nxt4.res = '{day: (d_s3.day < lim) ? d_s3.day : lim, mon: d_s3.r,
					year: d_s3.ny[11:0], err: cdau_pkg::ERR_NONE};
			end
		end
	end

	always_comb begin
		sel       = d_s4.a < d_s4.e_hi;
		e         = sel ? d_s4.e_lo : d_s4.e_hi;
		idx       = sel ? d_s4.est - 8'd1 : d_s4.est;
		diff      = d_s4.a - e + 17'd1;
		nxt5.fin  = d_s4.fin;
		nxt5.res  = d_s4.res;
		nxt5.rem  = diff[8:0];
		nxt5.year = cdau_pkg::YearMin + {4'd0, idx};
		nxt5.leap = cdau_pkg::leap_yr(nxt5.year);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= nxt4;
			d_s5 <= nxt5;
		end
	end

endmodule

### hdl/cdau_tail.sv
// Sixth stage: month search within the year and the output register.
module cdau_tail (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_s5,
	input  cdau_pkg::s5_t  d_s5,
	output logic           v_s6,
	output cdau_pkg::date_t d_s6
);

	cdau_pkg::date_t nxt;
	logic [3:0]      m;

	always_comb begin
		m = 4'd0;
		for (int j = 1; j < 12; j++) begin
			if (d_s5.rem > cdau_pkg::cum_days(4'(j), d_s5.leap)) begin
				m = 4'(j);
			end
		end
		if (d_s5.fin) begin
			nxt = d_s5.res;
		end else begin
			nxt.day  = 5'(d_s5.rem - cdau_pkg::cum_days(m, d_s5.leap));
			nxt.mon  = m;
			nxt.year = d_s5.year;
			nxt.err  = cdau_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6 <= nxt;
		end
	end

endmodule

### hdl/calendar_date_adder_unit.sv
// Calendar date adder: adds days, months or years to a Gregorian date.
// The unit is a six-stage pipeline. A beat enters on every cycle in which
// in_valid is high and in_stall is low; its result passes the stage registers
// s1 to s6 in order and is then presented on the output, so the sustained
// rate is one beat per cycle for as long as out_stall stays low.
// The day walk is done in closed form: the date is
// turned into a day count since 1900-01-01, divided by 365 through a
// reciprocal multiply, and corrected by one year; a final stage finds the
// month with eleven parallel compares. Month carry uses a reciprocal divide
// by twelve with floor behavior for negative amounts. Input and result dates
// are checked against 1900 to 2100, and any failure gives a zero date with
// the error code. The whole pipeline advances together; when a result waits
// on out_stall, every stage holds and in_stall is raised, so nothing is lost
// or repeated.
module calendar_date_adder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [4:0]          in_day,
	input  logic [3:0]          in_month,
	input  logic [11:0]         in_year,
	input  logic signed [17:0]  amount,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          out_day,
	output logic [3:0]          out_month,
	output logic [11:0]         out_year,
	output logic [1:0]          error
);

	logic            en;
	logic            v_s1;
	logic            v_s3;
	logic            v_s5;
	logic            v_s6;
	cdau_pkg::s1_t   d_s1;
	cdau_pkg::s3_t   d_s3;
	cdau_pkg::s5_t   d_s5;
	cdau_pkg::date_t d_s6;

	// The pipeline moves unless the output holds a beat that is being stalled.
	assign en       = !(v_s6 && out_stall);
	assign in_stall = !en;

	cdau_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_valid),
		.op(op), .in_day(in_day), .in_month(in_month), .in_year(in_year),
		.amount(amount), .v_s1(v_s1), .d_s1(d_s1)
	);

	cdau_core u_core (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_s1(v_s1), .d_s1(d_s1), .v_s3(v_s3), .d_s3(d_s3)
	);

	cdau_year u_year (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_s3(v_s3), .d_s3(d_s3), .v_s5(v_s5), .d_s5(d_s5)
	);

	cdau_tail u_tail (
		.clk(clk), .arst_n(arst_n), .en(en),
		.v_s5(v_s5), .d_s5(d_s5), .v_s6(v_s6), .d_s6(d_s6)
	);

	assign out_valid = v_s6;
	assign out_day   = d_s6.day;
	assign out_month = d_s6.mon;
	assign out_year  = d_s6.year;
	assign error     = d_s6.err;

endmodule

### hdl/cdau_checker.sv
// Port-level checks for the calendar date adder, bound to the top level.
module cdau_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [1:0]          op,
	input logic [4:0]          in_day,
	input logic [3:0]          in_month,
	input logic [11:0]         in_year,
	input logic signed [17:0]  amount,
	input logic                out_valid,
	input logic                out_stall,
	input logic [4:0]          out_day,
	input logic [3:0]          out_month,
	input logic [11:0]         out_year,
	input logic [1:0]          error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_day)
			&& $stable(out_month) && $stable(out_year) && $stable(error))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != cdau_pkg::ERR_NONE
			|-> out_day == 5'd0 && out_month == 4'd0 && out_year == 12'd0)
		else $error("failed result carries a nonzero date");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error == cdau_pkg::ERR_NONE
			|-> out_month <= 4'd11 && out_day >= 5'd1 && out_year >= 12'd1900
			&& out_year <= 12'd2100)
		else $error("good result has an impossible date");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the output stall");

endmodule

bind calendar_date_adder_unit cdau_checker u_cdau_checker (.*);

### dv/calendar_date_adder_unit_test.sv
// Self-checking testbench for the calendar date adder unit.
module calendar_date_adder_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no beat accepted on either side before the run is declared hung.
	// The worst correct gap is a long receiver hold plus a few stall bursts.
	localparam int HangLimit = 3000;
	// Latency headroom after the last result, well past the six-stage pipeline.
	localparam int DrainCycles = 20;
	localparam int LongHold = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [4:0]  in_day;
	logic [3:0]  in_month;
	logic [11:0] in_year;
	logic signed [17:0] amount;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [11:0] out_year;
	logic [1:0]  error;

	calendar_date_adder_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .in_day(in_day), .in_month(in_month), .in_year(in_year), .amount(amount),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_day(out_day), .out_month(out_month), .out_year(out_year), .error(error)
	);

	// Expected dates in the order their input beats were accepted.
	cdau_pkg::date_t pending_dates[$];
	int    mismatch_count;
	int    beats_sent;
	int    dates_checked;
	int    error_results;
	int    quiet_cycles;
	bit    sender_idling;
	bit    receiver_idling;
	int    hold_request;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Full Gregorian rule; the day walk can run past 2100 before it gives up.
	function automatic bit is_leap(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int month_days(int m, longint y);
		int n;
		case (m)
			1:              n = is_leap(y) ? 29 : 28;
			3, 5, 8, 10:    n = 30;
			default:        n = 31;
		endcase
		return n;
	endfunction

	// Computes the resulting date and error code of one input beat.
	function automatic cdau_pkg::date_t add_to_date(logic [1:0] op_c, logic [4:0] d,
			logic [3:0] m, logic [11:0] y, logic signed [17:0] a);
		cdau_pkg::date_t r;
		longint amt;
		longint doy;
		longint yy;
		longint len;
		longint v;
		longint q;
		longint rr;
		longint ny;
		int     rem;
		int     mm;
		int     lim;
		r = '0;
		amt = longint'(a);
		if (y < cdau_pkg::YearMin || y > cdau_pkg::YearMax) begin
			r.err = cdau_pkg::ERR_YEAR;
			return r;
		end
		if (m > 4'd11) begin
			r.err = cdau_pkg::ERR_MONTH;
			return r;
		end
		if (d < 1 || d > month_days(int'(m), longint'(y))) begin
			r.err = cdau_pkg::ERR_DAY;
			return r;
		end
		r.day = d;
		r.mon = m;
		r.year = y;
		r.err = cdau_pkg::ERR_NONE;
		if (op_c == cdau_pkg::OP_DAYS) begin
			// Walk whole years from the day of the year; a negative amount that
			// leaves the start year falls through and keeps the input date.
			doy = longint'(d);
			for (int i = 0; i < int'(m); i++) begin
				doy += month_days(i, longint'(y));
			end
			yy = longint'(y);
			while (amt + doy > 0) begin
				len = is_leap(yy) ? 366 : 365;
				if (amt + doy <= len) begin
					rem = int'(amt + doy);
					mm = 0;
					while (mm < 11 && rem > month_days(mm, yy)) begin
						rem -= month_days(mm, yy);
						mm++;
					end
					if (yy > cdau_pkg::YearMax) begin
						r = '0;
						r.err = cdau_pkg::ERR_YEAR;
					end else begin
						r.day = 5'(rem);
						r.mon = 4'(mm);
						r.year = 12'(yy);
					end
					return r;
				end
				amt -= len;
				yy++;
			end
		end else if (op_c == cdau_pkg::OP_MONTHS) begin
			// Floor carry of the month into the year, then clamp the day.
			v = longint'(m) + amt;
			q = v / 12;
			rr = v % 12;
			if (rr < 0) begin
				rr += 12;
				q -= 1;
			end
			ny = longint'(y) + q;
			if (ny < cdau_pkg::YearMin || ny > cdau_pkg::YearMax) begin
				r = '0;
				r.err = cdau_pkg::ERR_YEAR;
				return r;
			end
			lim = month_days(int'(rr), ny);
			r.day = (int'(d) < lim) ? d : 5'(lim);
			r.mon = 4'(rr);
			r.year = 12'(ny);
		end else if (op_c == cdau_pkg::OP_YEARS) begin
			ny = longint'(y) + amt;
			if (ny < cdau_pkg::YearMin || ny > cdau_pkg::YearMax) begin
				r = '0;
				r.err = cdau_pkg::ERR_YEAR;
				return r;
			end
			// February 29 becomes February 28 in a common year.
			if (is_leap(longint'(y)) && !is_leap(ny) && m == 4'd1 && d == 5'd29) begin
				r.day = 5'd28;
			end
			r.year = 12'(ny);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// One process samples both sides at the rising edge: an accepted input beat
	// queues its prediction, an accepted output beat is checked against the
	// oldest prediction. The pipeline latency keeps the two from touching the
	// same entry in one cycle.
	always @(posedge clk) begin
		cdau_pkg::date_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_dates.push_back(add_to_date(op, in_day, in_month, in_year, amount));
			end
			if (out_valid && !out_stall) begin
				if (pending_dates.size() == 0) begin
					$display("%0t result beat with nothing expected", $time);
					mismatch_count++;
				end else begin
					want = pending_dates.pop_front();
					if (out_day !== want.day)
						report_mismatch("out_day", out_day, want.day);
					if (out_month !== want.mon)
						report_mismatch("out_month", out_month, want.mon);
					if (out_year !== want.year)
						report_mismatch("out_year", out_year, want.year);
					if (error !== want.err)
						report_mismatch("error", error, want.err);
					dates_checked++;
					if (want.err != cdau_pkg::ERR_NONE)
						error_results++;
				end
			end
		end
	end

	// The receiver stalls in random bursts, or for a long stretch on request.
	initial begin
		int burst_left;
		burst_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_stall = 1'b1;
				hold_request--;
			end else if (burst_left > 0) begin
				out_stall = 1'b1;
				burst_left--;
			end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				burst_left = $urandom_range(0, 15);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: ends the run after too many cycles in which no beat moves.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < HangLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t timeout: no beat moved in %0d cycles", $time, HangLimit);
		$display("TEST FAILED");
		$finish;
	end

	// Sends one beat. Called at a falling edge, returns at a falling edge with
	// in_valid still high so that back-to-back beats need no gap.
	task automatic send_beat(logic [1:0] op_c, logic [4:0] d, logic [3:0] m,
			logic [11:0] y, logic signed [17:0] a);
		if (sender_idling && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		op = op_c;
		in_day = d;
		in_month = m;
		in_year = y;
		amount = a;
		in_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid = 1'b0;
		while (pending_dates.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Mostly valid dates with random content; now and then a broken field.
	task automatic send_random(logic [1:0] op_c, logic signed [17:0] a);
		logic [11:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		y = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(1900, 2100));
		m = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
		if ($urandom_range(0, 19) == 0 || m > 4'd11)
			d = 5'($urandom);
		else
			d = 5'($urandom_range(1, month_days(int'(m), longint'(y))));
		send_beat(op_c, d, m, y, a);
	endtask

	function automatic logic signed [17:0] random_amount(int reach);
		case ($urandom_range(0, 3))
			0:       return 18'($urandom);
			1:       return 18'($signed($urandom_range(0, 2 * reach)) - reach);
			default: return 18'($signed($urandom_range(0, 80)) - 40);
		endcase
	endfunction

	// Field extremes, every operation and each corner of the calendar rules.
	task automatic test_directed();
		send_beat(cdau_pkg::OP_DAYS, 5'd1, 4'd0, 12'd1899, 18'sd0);
		send_beat(cdau_pkg::OP_DAYS, 5'd1, 4'd0, 12'd2101, 18'sd0);
		send_beat(cdau_pkg::OP_MONTHS, 5'd31, 4'd15, 12'd4095, 18'sd0);
		send_beat(cdau_pkg::OP_YEARS, 5'd1, 4'd12, 12'd0, 18'sd0);
		send_beat(cdau_pkg::OP_DAYS, 5'd0, 4'd0, 12'd2000, 18'sd1);
		send_beat(cdau_pkg::OP_DAYS, 5'd31, 4'd3, 12'd2000, 18'sd1);
		send_beat(cdau_pkg::OP_DAYS, 5'd29, 4'd1, 12'd1900, 18'sd1);
		send_beat(cdau_pkg::OP_DAYS, 5'd29, 4'd1, 12'd2000, 18'sd1);
		send_beat(cdau_pkg::OP_NOP, 5'd15, 4'd6, 12'd1950, 18'sd1000);
		send_beat(cdau_pkg::OP_DAYS, 5'd1, 4'd0, 12'd1990, -18'sd5);
		send_beat(cdau_pkg::OP_DAYS, 5'd31, 4'd11, 12'd2100, 18'sd1);
		send_beat(cdau_pkg::OP_DAYS, 5'd31, 4'd11, 12'd2099, 18'sd1);
		send_beat(cdau_pkg::OP_DAYS, 5'd1, 4'd0, 12'd1900, 18'sd131071);
		send_beat(cdau_pkg::OP_DAYS, 5'd31, 4'd11, 12'd2100, -18'sd131072);
		send_beat(cdau_pkg::OP_DAYS, 5'd1, 4'd0, 12'd1900, 18'sd73413);
		send_beat(cdau_pkg::OP_MONTHS, 5'd31, 4'd0, 12'd2000, 18'sd1);
		send_beat(cdau_pkg::OP_MONTHS, 5'd31, 4'd0, 12'd2001, -18'sd1);
		send_beat(cdau_pkg::OP_MONTHS, 5'd10, 4'd5, 12'd2000, 18'sd131071);
		send_beat(cdau_pkg::OP_MONTHS, 5'd10, 4'd5, 12'd2000, -18'sd131072);
		send_beat(cdau_pkg::OP_MONTHS, 5'd1, 4'd0, 12'd1900, 18'sd2411);
		send_beat(cdau_pkg::OP_YEARS, 5'd29, 4'd1, 12'd2000, 18'sd1);
		send_beat(cdau_pkg::OP_YEARS, 5'd29, 4'd1, 12'd2000, 18'sd4);
		send_beat(cdau_pkg::OP_YEARS, 5'd1, 4'd0, 12'd2100, 18'sd1);
		send_beat(cdau_pkg::OP_YEARS, 5'd1, 4'd0, 12'd2000, -18'sd131072);
		wait_for_results();
	endtask

	task automatic test_day_walk(int n);
		for (int i = 0; i < n; i++)
			send_random(cdau_pkg::OP_DAYS, random_amount(75000));
		wait_for_results();
	endtask

	task automatic test_month_carry(int n);
		for (int i = 0; i < n; i++)
			send_random(cdau_pkg::OP_MONTHS, random_amount(2500));
		wait_for_results();
	endtask

	task automatic test_year_shift(int n);
		for (int i = 0; i < n; i++)
			send_random(cdau_pkg::OP_YEARS, random_amount(220));
		wait_for_results();
	endtask

	task automatic test_mixed(int n);
		for (int i = 0; i < n; i++)
			send_random(2'($urandom), random_amount(3000));
	endtask

	// The receiver holds off long enough that the pipeline fills and stalls
	// the sender, which keeps offering beats apart from its random pauses.
	task automatic test_full_pipeline();
		hold_request = LongHold;
		test_mixed(40);
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = cdau_pkg::OP_DAYS;
		in_day = '0;
		in_month = '0;
		in_year = '0;
		amount = '0;
		mismatch_count = 0;
		beats_sent = 0;
		dates_checked = 0;
		error_results = 0;
		hold_request = 0;
		sender_idling = 1'b1;
		receiver_idling = 1'b1;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_day_walk(250);
		test_month_carry(200);
		test_year_shift(200);
		test_full_pipeline();
		test_mixed(150);
		// The sender pauses here until every result is back.
		wait_for_results();
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		test_mixed(200);
		wait_for_results();

		$display("Covered %0d input beats and %0d checked results, %0d of them error codes,",
			beats_sent, dates_checked, error_results);
		$display("across day walks, month carries, year shifts and a full pipeline hold.");
		if (mismatch_count == 0 && pending_dates.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/cdau_pkg.sv
hdl/cdau_front.sv
hdl/cdau_core.sv
hdl/cdau_year.sv
hdl/cdau_tail.sv
hdl/calendar_date_adder_unit.sv
hdl/cdau_checker.sv
dv/calendar_date_adder_unit_test.sv
